// File: rtl/spk_pkg.sv
// Shared types and constants for the spectrum peak search block.
package spk_pkg;

  localparam int unsigned FREQ_W  = 35;
  localparam int unsigned AMP_W   = 16;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned SCALE_W = FREQ_W + 5;  // room for frequency times 21
  localparam int unsigned CFG_AW  = 2;
  localparam int unsigned CFG_DW  = 16;

  // Result queue geometry.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;
  localparam int unsigned Q_LW    = 3;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] REG_NOISE_FLOOR = 2'd0;
  localparam logic [CFG_AW-1:0] REG_THRESHOLD   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_PEAK_LIMIT  = 2'd2;

  // Result kinds.
  localparam logic KIND_PEAK    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Reset values of the configuration registers.
  localparam logic signed [AMP_W-1:0] NOISE_FLOOR_RST = 16'sd0;
  localparam logic signed [AMP_W-1:0] THRESHOLD_RST   = 16'sd384;
  localparam logic [CNT_W-1:0]        PEAK_LIMIT_RST  = 16'd64;

  typedef struct packed {
    logic signed [AMP_W-1:0] noise_floor;
    logic signed [AMP_W-1:0] threshold;
    logic [CNT_W-1:0]        peak_limit;
  } spk_cfg_t;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  index;
    logic [FREQ_W-1:0] freq;
    logic [CNT_W-1:0]  count;
    logic              last;
  } spk_result_t;

  // Results produced by one accepted point: zero, one or two.
  typedef struct packed {
    logic [1:0]  num;
    spk_result_t r0;
    spk_result_t r1;
  } spk_push_t;

  typedef struct packed {
    logic [Q_LW-1:0] level;
  } spk_qstat_t;

endpackage

// File: rtl/spectrum_peak_search_top.sv
// Spectrum peak search: local-maximum detection over a streamed scan, top level.
//
// One scan point is taken per clock cycle while input ready is high. Each point is
// tested in the cycle it is accepted, against a three-point window of two registered
// points and the incoming one: the middle point is reported as a peak when it is
// strictly above both neighbors, strictly above the noise floor plus the threshold,
// more than 1.05 times the frequency of the last reported peak (checked exactly as
// f*20 > last*21), and the scan has not yet hit the peak limit. The point flagged
// end_of_scan is followed by a summary result with the total peak count, and the
// scan state then returns to its reset values; the configuration registers keep
// their values across scans. Results leave one per cycle while output ready is high,
// from a four-entry queue. Input ready is held low while fewer than two queue entries
// are free, which means the sustained input rate is one point per cycle as long as
// results are taken as fast as they appear; a point that yields both a peak and a
// summary fills two queue entries. Points at index MAX_POINTS - 1 or beyond are not
// tested for peaks. Configuration should be written only while no request is in flight.
module spectrum_peak_search_top import spk_pkg::*; #(
  parameter int unsigned MAX_POINTS = 65536
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Scan point requests.
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [FREQ_W-1:0]       frequency_i,
  input  logic signed [AMP_W-1:0] amplitude_i,
  input  logic                    end_of_scan_i,
  // Results.
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    result_kind_o,
  output logic [IDX_W-1:0]        point_index_o,
  output logic [FREQ_W-1:0]       peak_frequency_o,
  output logic [CNT_W-1:0]        peak_count_o,
  output logic                    last_of_run_o,
  // Configuration writes.
  input  logic                    cfg_we_i,
  input  logic [CFG_AW-1:0]       cfg_index_i,
  input  logic [CFG_DW-1:0]       cfg_data_i
);

  spk_cfg_t    cfg_q;
  spk_push_t   push;
  spk_result_t head;
  spk_qstat_t  qstat;
  logic        in_accept;

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.noise_floor <= NOISE_FLOOR_RST;
      cfg_q.threshold   <= THRESHOLD_RST;
      cfg_q.peak_limit  <= PEAK_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_NOISE_FLOOR: cfg_q.noise_floor <= cfg_data_i;
        REG_THRESHOLD:   cfg_q.threshold   <= cfg_data_i;
        REG_PEAK_LIMIT:  cfg_q.peak_limit  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // A request can produce two results, so two free entries are needed to take one.
  assign in_ready_o = (qstat.level <= Q_LW'(Q_DEPTH - 2));
  assign in_accept  = in_valid_i && in_ready_o;

  spk_detect #(
    .MAX_POINTS (MAX_POINTS)
  ) u_detect (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .frequency_i   (frequency_i),
    .amplitude_i   (amplitude_i),
    .end_of_scan_i (end_of_scan_i),
    .cfg_i         (cfg_q),
    .push_o        (push)
  );

  spk_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_ready_i),
    .valid_o (out_valid_o),
    .head_o  (head),
    .stat_o  (qstat)
  );

  assign result_kind_o    = head.kind;
  assign point_index_o    = head.index;
  assign peak_frequency_o = head.freq;
  assign peak_count_o     = head.count;
  assign last_of_run_o    = head.last;

  // The queue never holds more entries than it has.
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.level <= Q_LW'(Q_DEPTH))
    else $error("result queue overfilled");

  // The end of a scan always leaves a summary waiting.
  a_eos_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && end_of_scan_i) |=> out_valid_o)
    else $error("no result after end of scan");

  // A summary is always the final result of its request.
  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KIND_SUMMARY) |-> last_of_run_o)
    else $error("summary not marked last");

  // A peak can only be reported with a nonzero count.
  a_peak_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KIND_PEAK) |-> (peak_count_o != '0))
    else $error("peak reported with zero count");

endmodule

// File: rtl/spk_detect.sv
// Three-point window, peak tests and per-scan state of the peak search.
module spk_detect import spk_pkg::*; #(
  parameter int unsigned MAX_POINTS = 65536
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [FREQ_W-1:0]       frequency_i,
  input  logic signed [AMP_W-1:0] amplitude_i,
  input  logic                    end_of_scan_i,
  input  spk_cfg_t                cfg_i,
  output spk_push_t               push_o
);

  localparam int unsigned PTS_W = $clog2(MAX_POINTS + 1);

  logic signed [AMP_W-1:0] older_q, middle_q;
  logic [FREQ_W-1:0]       mid_freq_q;
  logic [SCALE_W-1:0]      mid_freq20_q;
  logic [SCALE_W-1:0]      last_freq21_q;
  logic [PTS_W-1:0]        pts_q;
  logic [CNT_W-1:0]        found_q;

  logic signed [AMP_W:0]   level;
  logic signed [AMP_W:0]   mid_ext;
  logic                    in_window;
  logic                    is_local;
  logic                    spaced;
  logic                    hit;
  logic [CNT_W-1:0]        found_next;
  logic [SCALE_W-1:0]      freq20;
  spk_result_t             peak_res, sum_res;

  // Exact 17-bit sum so the level can never wrap.
  assign level   = {cfg_i.noise_floor[AMP_W-1], cfg_i.noise_floor}
                 + {cfg_i.threshold[AMP_W-1], cfg_i.threshold};
  assign mid_ext = {middle_q[AMP_W-1], middle_q};

  assign in_window = (pts_q >= PTS_W'(2)) && (pts_q < PTS_W'(MAX_POINTS));
  assign is_local  = (middle_q > older_q) && (middle_q > amplitude_i) && (mid_ext > level);
  // More than 1.05 times the last peak, kept in integers as f*20 > last*21.
  assign spaced    = (found_q == '0) || (mid_freq20_q > last_freq21_q);
  assign hit       = in_window && is_local && spaced && (found_q < cfg_i.peak_limit);

  assign found_next = hit ? found_q + CNT_W'(1) : found_q;
  assign freq20     = (SCALE_W'(frequency_i) << 4) + (SCALE_W'(frequency_i) << 2);

  always_comb begin
    peak_res.kind  = KIND_PEAK;
    peak_res.index = IDX_W'(pts_q - PTS_W'(1));
    peak_res.freq  = mid_freq_q;
    peak_res.count = found_next;
    peak_res.last  = ~end_of_scan_i;

    sum_res.kind   = KIND_SUMMARY;
    sum_res.index  = '0;
    sum_res.freq   = '0;
    sum_res.count  = found_next;
    sum_res.last   = 1'b1;

    push_o.r0 = hit ? peak_res : sum_res;
    push_o.r1 = sum_res;
    if (!accept_i) begin
      push_o.num = 2'd0;
    end else if (hit && end_of_scan_i) begin
      push_o.num = 2'd2;
    end else if (hit || end_of_scan_i) begin
      push_o.num = 2'd1;
    end else begin
      push_o.num = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q       <= '0;
      middle_q      <= '0;
      mid_freq_q    <= '0;
      mid_freq20_q  <= '0;
      last_freq21_q <= '0;
      pts_q         <= '0;
      found_q       <= '0;
    end else if (accept_i) begin
      if (end_of_scan_i) begin
        older_q       <= '0;
        middle_q      <= '0;
        mid_freq_q    <= '0;
        mid_freq20_q  <= '0;
        last_freq21_q <= '0;
        pts_q         <= '0;
        found_q       <= '0;
      end else begin
        older_q      <= middle_q;
        middle_q     <= amplitude_i;
        mid_freq_q   <= frequency_i;
        mid_freq20_q <= freq20;
        if (pts_q < PTS_W'(MAX_POINTS)) begin
          pts_q <= pts_q + PTS_W'(1);
        end
        found_q <= found_next;
        if (hit) begin
          last_freq21_q <= mid_freq20_q + SCALE_W'(mid_freq_q);
        end
      end
    end
  end

endmodule

// File: rtl/spk_outq.sv
// Small result queue that takes up to two results a cycle and hands out one.
module spk_outq import spk_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  spk_push_t   push_i,
  input  logic        pop_i,
  output logic        valid_o,
  output spk_result_t head_o,
  output spk_qstat_t  stat_o
);

  spk_result_t      mem_q [Q_DEPTH];
  logic [Q_AW-1:0]  wptr_q, rptr_q;
  logic [Q_LW-1:0]  level_q;
  logic             do_pop;

  assign valid_o      = (level_q != '0);
  assign head_o       = mem_q[rptr_q];
  assign stat_o.level = level_q;
  assign do_pop       = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wptr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[Q_AW'(wptr_q + Q_AW'(1))] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      wptr_q  <= wptr_q + Q_AW'(push_i.num);
      if (do_pop) begin
        rptr_q <= rptr_q + Q_AW'(1);
      end
      level_q <= level_q + Q_LW'(push_i.num) - Q_LW'(do_pop);
    end
  end

endmodule

// File: dv/tb.sv
// Self-checking testbench for the spectrum peak search block.
module tb;
  import spk_pkg::*;

  // Saturation point of the per-scan point counter; the block is built with the same value.
  localparam int unsigned SCAN_POINTS_MAX = 65536;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_ready_o;
  logic [FREQ_W-1:0]       frequency_i   = '0;
  logic signed [AMP_W-1:0] amplitude_i   = '0;
  logic                    end_of_scan_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i   = 1'b0;
  logic                    result_kind_o;
  logic [IDX_W-1:0]        point_index_o;
  logic [FREQ_W-1:0]       peak_frequency_o;
  logic [CNT_W-1:0]        peak_count_o;
  logic                    last_of_run_o;
  logic                    cfg_we_i      = 1'b0;
  logic [CFG_AW-1:0]       cfg_index_i   = REG_NOISE_FLOOR;
  logic [CFG_DW-1:0]       cfg_data_i    = '0;

  spectrum_peak_search_top #(.MAX_POINTS(SCAN_POINTS_MAX)) uut (.*);

  initial forever #5 clk_i = ~clk_i;

  // Random idling on both sides is enabled while this is set.
  bit idle_on = 1'b1;
  int stall_left = 0;
  int mismatch_count = 0;

  // Peaks and summaries predicted for accepted points, oldest first.
  spk_result_t pending_results[$];

  // Shadow copy of the configuration registers.
  int          noise_floor_q = int'(NOISE_FLOOR_RST);
  int          threshold_q   = int'(THRESHOLD_RST);
  int unsigned peak_limit_q  = int'(PEAK_LIMIT_RST);

  // Shadow copy of the scan state: the three-point window and the peak bookkeeping.
  int                older_amp       = 0;
  int                middle_amp      = 0;
  logic [FREQ_W-1:0] middle_freq     = '0;
  int unsigned       points_in_scan  = 0;
  int unsigned       peaks_in_scan   = 0;
  logic [FREQ_W-1:0] last_peak_freq  = '0;

  // Advances the window by one point and queues the peak and summary that it yields.
  function automatic void search_window_step(input logic [FREQ_W-1:0] freq,
                                             input logic signed [AMP_W-1:0] amp,
                                             input logic last_point);
    int          level;
    bit          is_local;
    bit          is_spaced;
    spk_result_t r;
    if (points_in_scan >= 2 && points_in_scan < SCAN_POINTS_MAX) begin
      // The floor plus threshold is a 17-bit sum, so no saturation is involved.
      level     = noise_floor_q + threshold_q;
      is_local  = middle_amp > older_amp && middle_amp > int'(amp) && middle_amp > level;
      // More than 1.05 times the last peak, evaluated in integers.
      is_spaced = peaks_in_scan == 0 ||
                  {29'd0, middle_freq} * 64'd20 > {29'd0, last_peak_freq} * 64'd21;
      if (is_local && is_spaced && peaks_in_scan < peak_limit_q) begin
        peaks_in_scan++;
        last_peak_freq = middle_freq;
        r.kind  = KIND_PEAK;
        r.index = IDX_W'(points_in_scan - 1);
        r.freq  = middle_freq;
        r.count = CNT_W'(peaks_in_scan);
        r.last  = !last_point;
        pending_results.push_back(r);
      end
    end
    older_amp   = middle_amp;
    middle_amp  = int'(amp);
    middle_freq = freq;
    if (points_in_scan < SCAN_POINTS_MAX) points_in_scan++;
    if (last_point) begin
      r.kind  = KIND_SUMMARY;
      r.index = '0;
      r.freq  = '0;
      r.count = CNT_W'(peaks_in_scan);
      r.last  = 1'b1;
      pending_results.push_back(r);
      older_amp      = 0;
      middle_amp     = 0;
      middle_freq    = '0;
      points_in_scan = 0;
      peaks_in_scan  = 0;
      last_peak_freq = '0;
    end
  endfunction

  // Sends one scan point. Valid is left high on return so that a following point can go
  // out back to back; anything that pauses the stream lowers it first.
  task automatic send_point(input logic [FREQ_W-1:0] freq,
                            input logic signed [AMP_W-1:0] amp,
                            input logic last_point);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    frequency_i   <= freq;
    amplitude_i   <= amp;
    end_of_scan_i <= last_point;
    do @(posedge clk_i); while (!in_ready_o);
    search_window_step(freq, amp, last_point);
  endtask

  // Stops the stream and waits for every predicted result, then lets the points that
  // produce no result settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all three registers in consecutive cycles; the block must be idle.
  task automatic program_registers(input int noise, input int thresh, input int unsigned peaks);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_NOISE_FLOOR;
    cfg_data_i  <= CFG_DW'(noise);
    @(posedge clk_i);
    cfg_index_i <= REG_THRESHOLD;
    cfg_data_i  <= CFG_DW'(thresh);
    @(posedge clk_i);
    cfg_index_i <= REG_PEAK_LIMIT;
    cfg_data_i  <= CFG_DW'(peaks);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    noise_floor_q = noise;
    threshold_q   = thresh;
    peak_limit_q  = peaks;
  endtask

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("[tb] %0t: %s expected 0x%0h, got 0x%0h", $realtime, name, want, got);
    end
  endtask

  // Result side: compares each accepted result with the oldest prediction and throttles
  // ready in random bursts.
  always @(posedge clk_i) begin
    spk_result_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[tb] %0t: result kind %0d index %0d arrived with nothing pending",
                   $realtime, result_kind_o, point_index_o);
      end else begin
        want = pending_results.pop_front();
        report_field("result_kind", 64'(want.kind), 64'(result_kind_o));
        report_field("point_index", 64'(want.index), 64'(point_index_o));
        report_field("peak_frequency", 64'(want.freq), 64'(peak_frequency_o));
        report_field("peak_count", 64'(want.count), 64'(peak_count_o));
        report_field("last_of_run", 64'(want.last), 64'(last_of_run_o));
      end
    end
    if (stall_left != 0) stall_left--;
    else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 13);
    out_ready_i <= (stall_left == 0);
  end

  // Power-on register values: single-point and two-point scans give an empty summary,
  // a point just above the level is a peak, one equal to it is not, and the point just
  // before the end of the scan yields a peak and the summary from one request.
  task automatic check_reset_defaults();
    send_point(FREQ_W'(5), 16'sd32767, 1'b1);
    send_point(FREQ_W'(1), 16'sd100, 1'b0);
    send_point(FREQ_W'(2), 16'sd200, 1'b1);
    send_point('0, 16'sd0, 1'b0);
    send_point(FREQ_W'(100), 16'sd385, 1'b0);
    send_point('1, 16'sd384, 1'b0);
    send_point('1, 16'sd32767, 1'b0);
    send_point('1, -16'sd32768, 1'b1);
    drain_results();
  endtask

  // Level of zero and at most two peaks: a middle point equal to the level, one at
  // exactly 1.05 times the last peak, one just past it, and one beyond the peak limit.
  task automatic check_peak_rules();
    program_registers(-100, 100, 2);
    send_point(FREQ_W'(10), -16'sd5, 1'b0);
    send_point(FREQ_W'(20), 16'sd0, 1'b0);
    send_point(FREQ_W'(30), -16'sd5, 1'b0);
    send_point(FREQ_W'(20), 16'sd50, 1'b0);
    send_point(FREQ_W'(21), -16'sd5, 1'b0);
    send_point(FREQ_W'(21), 16'sd60, 1'b0);
    send_point(FREQ_W'(0), -16'sd5, 1'b0);
    send_point(FREQ_W'(22), 16'sd60, 1'b0);
    send_point(FREQ_W'(0), -16'sd5, 1'b0);
    send_point(FREQ_W'(1000), 16'sd70, 1'b0);
    send_point(FREQ_W'(5), -16'sd5, 1'b1);
    drain_results();
  endtask

  // A peak limit of zero suppresses an obvious peak.
  task automatic check_zero_peak_limit();
    program_registers(0, 0, 0);
    send_point(FREQ_W'(1), 16'sd0, 1'b0);
    send_point(FREQ_W'(2), 16'sd1000, 1'b0);
    send_point(FREQ_W'(3), 16'sd0, 1'b1);
    drain_results();
  endtask

  // Several register settings, each with scans of random length. Amplitudes mostly sit
  // around the detection level so peaks are frequent; frequencies mostly climb by a few
  // percent per point so that the spacing rule both passes and fails. The stream is
  // paused midway through each setting and at its end until all results are in. The
  // last setting runs without idling on either side.
  task automatic check_random_scans();
    int                      scan_len;
    int                      sent;
    int                      level;
    int                      amp_int;
    logic [FREQ_W-1:0]       freq_walk;
    logic [FREQ_W-1:0]       freq;
    logic signed [AMP_W-1:0] amp;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: program_registers(-32768, 32767, 65535);
        1: program_registers(32767, 32767, 3);
        2: program_registers(int'($urandom_range(0, 4000)) - 2000,
                             int'($urandom_range(0, 1000)) - 500, $urandom_range(1, 4));
        3: program_registers(int'($urandom_range(0, 65535)) - 32768,
                             int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 2));
        default: begin
          idle_on = 1'b0;
          program_registers(int'($urandom_range(0, 6000)) - 3000, 384, 64);
        end
      endcase
      level = noise_floor_q + threshold_q;
      sent  = 0;
      while (sent < 90) begin
        case ($urandom_range(0, 9))
          0:       scan_len = $urandom_range(1, 2);
          1:       scan_len = $urandom_range(40, 120);
          default: scan_len = $urandom_range(3, 30);
        endcase
        if ($urandom_range(0, 9) == 0) freq_walk = FREQ_W'({$urandom, $urandom});
        else freq_walk = FREQ_W'($urandom_range(0, 1 << 20));
        for (int i = 0; i < scan_len; i++) begin
          if ($urandom_range(0, 1) == 0) freq_walk = freq_walk + freq_walk / 12 + 1;
          else freq_walk = freq_walk + freq_walk / 40 + FREQ_W'($urandom_range(0, 64));
          freq = ($urandom_range(0, 7) == 0) ? FREQ_W'({$urandom, $urandom}) : freq_walk;
          if ($urandom_range(0, 3) == 0) begin
            amp = AMP_W'($urandom);
          end else begin
            amp_int = level + int'($urandom_range(0, 160)) - 60;
            if (amp_int > 32767) amp_int = 32767;
            if (amp_int < -32768) amp_int = -32768;
            amp = AMP_W'(amp_int);
          end
          send_point(freq, amp, i == scan_len - 1);
          sent++;
          if (sent == 45) drain_results();
        end
      end
      drain_results();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_reset_defaults();
    check_peak_rules();
    check_zero_peak_limit();
    check_random_scans();
    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin
    #6000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
